// ===== rtl/lpffp_pkg.sv =====
// shared types, codes and helper functions of the length-prefixed frame field parser
package lpffp_pkg;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_EXT     = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_HALTED  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    KIND_OPEN,
    KIND_CLOSE,
    KIND_STREAM,
    KIND_CONFIRM,
    KIND_UNKNOWN
  } kind_t;

  localparam logic [2:0] ROLE_NONE      = 3'd0;
  localparam logic [2:0] ROLE_BAUD      = 3'd1;
  localparam logic [2:0] ROLE_NAME_LEN  = 3'd2;
  localparam logic [2:0] ROLE_NAME_CHAR = 3'd3;
  localparam logic [2:0] ROLE_XFER_ID   = 3'd4;
  localparam logic [2:0] ROLE_DATA      = 3'd5;
  localparam logic [2:0] ROLE_OTHER     = 3'd6;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_SHORT     = 3'd1;
  localparam logic [2:0] STATUS_OVERRUN   = 3'd2;
  localparam logic [2:0] STATUS_UNKNOWN   = 3'd3;
  localparam logic [2:0] STATUS_TOO_LARGE = 3'd4;

  localparam logic [2:0] CFG_OPEN_CODE    = 3'd0;
  localparam logic [2:0] CFG_CLOSE_CODE   = 3'd1;
  localparam logic [2:0] CFG_STREAM_CODE  = 3'd2;
  localparam logic [2:0] CFG_CONFIRM_CODE = 3'd3;
  localparam logic [2:0] CFG_MAX_LENGTH   = 3'd4;

  localparam logic [2:0]  RST_OPEN_CODE    = 3'd0;
  localparam logic [2:0]  RST_CLOSE_CODE   = 3'd1;
  localparam logic [2:0]  RST_STREAM_CODE  = 3'd2;
  localparam logic [2:0]  RST_CONFIRM_CODE = 3'd3;
  localparam logic [31:0] RST_MAX_LENGTH   = 32'd65536;

  localparam logic [4:0] LEN_EXTENDED    = 5'd31;
  localparam logic [1:0] EXT_LAST_BYTE   = 2'd3;
  localparam logic [2:0] FIXED_OPEN      = 3'd6;
  localparam logic [2:0] FIXED_OTHER     = 3'd2;
  localparam logic [2:0] BAUD_BYTES      = 3'd4;
  localparam logic [2:0] XFER_ID_BYTES   = 3'd4;

  typedef struct packed {
    logic [2:0]  open_code;
    logic [2:0]  close_code;
    logic [2:0]  stream_code;
    logic [2:0]  confirm_code;
    logic [31:0] max_frame_length;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  opcode;
    logic [31:0] length;
    logic [7:0]  value;
    logic [2:0]  role;
    logic [31:0] offset;
    logic        last;
    logic [2:0]  status;
  } result_t;

  // match order is open, close, stream, confirm
  function automatic kind_t kind_of(input logic [2:0] op, input cfg_t cfg);
    kind_t k;
    if (op == cfg.open_code) k = KIND_OPEN;
    else if (op == cfg.close_code) k = KIND_CLOSE;
    else if (op == cfg.stream_code) k = KIND_STREAM;
    else if (op == cfg.confirm_code) k = KIND_CONFIRM;
    else k = KIND_UNKNOWN;
    return k;
  endfunction

endpackage

// ===== rtl/lpffp_engine.sv =====
// parse state and per-byte role and status logic of the frame parser
module lpffp_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        data,
  input  lpffp_pkg::cfg_t    cfg,
  output lpffp_pkg::result_t res
);
  import lpffp_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  ext_count, ext_count_next;
  logic [2:0]  cur_opcode, cur_opcode_next;
  logic [31:0] decl_len, decl_len_next;
  logic [31:0] bytes_taken, bytes_taken_next;
  logic [15:0] name_len, name_len_next;

  logic [2:0]  op_eff;
  logic [31:0] len_eff;
  kind_t       kind;
  logic [2:0]  fixed;
  logic [2:0]  name_start;
  logic [16:0] name_end;
  logic [17:0] xfer_end;
  logic [2:0]  role;
  logic [15:0] name_len_new;
  logic [16:0] check_sum;
  logic [32:0] off_plus;
  logic        last;
  logic [2:0]  end_status;

  // opcode and length seen by this byte, header bytes included
  always_comb begin
    op_eff  = cur_opcode;
    len_eff = decl_len;
    if (phase == PH_HEADER) begin
      op_eff  = data[2:0];
      len_eff = (data[7:3] == LEN_EXTENDED) ? 32'd0 : {27'd0, data[7:3]};
    end else if (phase == PH_EXT) begin
      len_eff = {decl_len[23:0], data};
    end
  end

  assign kind       = kind_of(op_eff, cfg);
  assign fixed      = (kind == KIND_CLOSE) ? FIXED_OTHER : FIXED_OPEN;
  assign name_start = (kind == KIND_OPEN) ? FIXED_OPEN : FIXED_OTHER;
  assign name_end   = {14'd0, name_start} + {1'b0, name_len};
  assign xfer_end   = {1'b0, name_end} + {15'd0, XFER_ID_BYTES};

  always_comb begin
    if (kind == KIND_UNKNOWN) role = ROLE_OTHER;
    else if (kind == KIND_OPEN && bytes_taken < {29'd0, BAUD_BYTES}) role = ROLE_BAUD;
    else if (bytes_taken < {29'd0, name_start}) role = ROLE_NAME_LEN;
    else if (bytes_taken < {15'd0, name_end}) role = ROLE_NAME_CHAR;
    else if ((kind == KIND_STREAM || kind == KIND_CONFIRM) &&
             bytes_taken < {14'd0, xfer_end}) role = ROLE_XFER_ID;
    else if (kind == KIND_STREAM) role = ROLE_DATA;
    else role = ROLE_OTHER;
  end

  // the name length byte of this item already counts toward the end check
  assign name_len_new = (role == ROLE_NAME_LEN) ? {name_len[7:0], data} : name_len;
  assign check_sum    = {1'b0, name_len_new} + {14'd0, fixed};
  assign off_plus     = {1'b0, bytes_taken} + 33'd1;
  assign last         = off_plus >= {1'b0, decl_len};

  always_comb begin
    if (kind == KIND_UNKNOWN) end_status = STATUS_UNKNOWN;
    else if (decl_len < {29'd0, fixed}) end_status = STATUS_SHORT;
    else if ({15'd0, check_sum} > decl_len) end_status = STATUS_OVERRUN;
    else end_status = STATUS_OK;
  end

  always_comb begin
    phase_next       = phase;
    ext_count_next   = ext_count;
    cur_opcode_next  = cur_opcode;
    decl_len_next    = decl_len;
    bytes_taken_next = bytes_taken;
    name_len_next    = name_len;
    res              = '0;
    res.opcode       = op_eff;
    res.length       = len_eff;
    res.role         = ROLE_NONE;
    res.status       = STATUS_OK;
    case (phase)
      PH_HEADER, PH_EXT: begin
        cur_opcode_next = op_eff;
        decl_len_next   = len_eff;
        if (phase == PH_HEADER && data[7:3] == LEN_EXTENDED) begin
          phase_next     = PH_EXT;
          ext_count_next = 2'd0;
        end else if (phase == PH_EXT && ext_count != EXT_LAST_BYTE) begin
          ext_count_next = ext_count + 2'd1;
        end else if (len_eff > cfg.max_frame_length) begin
          phase_next = PH_HALTED;
          res.valid  = 1'b1;
          res.last   = 1'b1;
          res.status = STATUS_TOO_LARGE;
        end else begin
          bytes_taken_next = 32'd0;
          name_len_next    = 16'd0;
          if (len_eff == 32'd0) begin
            // empty frame: a known kind is always short here
            phase_next = PH_HEADER;
            res.valid  = 1'b1;
            res.last   = 1'b1;
            res.status = (kind == KIND_UNKNOWN) ? STATUS_UNKNOWN : STATUS_SHORT;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        name_len_next    = name_len_new;
        bytes_taken_next = off_plus[31:0];
        res.valid        = 1'b1;
        res.value        = data;
        res.role         = role;
        res.offset       = bytes_taken;
        res.last         = last;
        res.status       = last ? end_status : STATUS_OK;
        if (last) phase_next = PH_HEADER;
      end
      PH_HALTED: begin
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      ext_count   <= 2'd0;
      cur_opcode  <= 3'd0;
      decl_len    <= 32'd0;
      bytes_taken <= 32'd0;
      name_len    <= 16'd0;
    end else if (fire) begin
      phase       <= phase_next;
      ext_count   <= ext_count_next;
      cur_opcode  <= cur_opcode_next;
      decl_len    <= decl_len_next;
      bytes_taken <= bytes_taken_next;
      name_len    <= name_len_next;
    end
  end

endmodule

// ===== rtl/length_prefixed_frame_field_parser.sv =====
// top level of the length-prefixed frame field parser: input, config and result registers
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------------
//  in      | in_valid/in_ready   | data_byte
//  out     | out_valid/out_ready | frame_opcode frame_length byte_value byte_role
//          |                    | byte_offset frame_last frame_status
//  cfg     | cfg_valid/cfg_ready | cfg_index cfg_data (always ready)
//
// one byte per cycle sustained unless a result stalls; a byte goes input register ->
// parse logic -> result register, loaded when the input register advances
// synchronous reset clears the parse state and the config registers to their defaults
// a stalled result holds the input register, and in_ready drops only while both are full
// after a too-large length every byte is still taken but gives no result until reset
module length_prefixed_frame_field_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  frame_opcode,
  output logic [31:0] frame_length,
  output logic [7:0]  byte_value,
  output logic [2:0]  byte_role,
  output logic [31:0] byte_offset,
  output logic        frame_last,
  output logic [2:0]  frame_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import lpffp_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;
  result_t    res;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_code        <= RST_OPEN_CODE;
      cfg.close_code       <= RST_CLOSE_CODE;
      cfg.stream_code      <= RST_STREAM_CODE;
      cfg.confirm_code     <= RST_CONFIRM_CODE;
      cfg.max_frame_length <= RST_MAX_LENGTH;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OPEN_CODE:    cfg.open_code        <= cfg_data[2:0];
        CFG_CLOSE_CODE:   cfg.close_code       <= cfg_data[2:0];
        CFG_STREAM_CODE:  cfg.stream_code      <= cfg_data[2:0];
        CFG_CONFIRM_CODE: cfg.confirm_code     <= cfg_data[2:0];
        CFG_MAX_LENGTH:   cfg.max_frame_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_byte <= data_byte;
  end

  lpffp_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .data (s1_byte),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      frame_opcode <= res.opcode;
      frame_length <= res.length;
      byte_value   <= res.value;
      byte_role    <= res.role;
      byte_offset  <= res.offset;
      frame_last   <= res.last;
      frame_status <= res.status;
    end
  end

endmodule

// ===== rtl/lpffp_checker.sv =====
// port-level checks of the frame parser and their bind to the top level
module lpffp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] frame_length,
  input logic [7:0]  byte_value,
  input logic [2:0]  byte_role,
  input logic [31:0] byte_offset,
  input logic        frame_last,
  input logic [2:0]  frame_status
);
  import lpffp_pkg::*;

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_value) && $stable(byte_offset)
      && $stable(frame_status) && $stable(frame_last))
    else $error("result changed while stalled");

  a_status_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_last |-> frame_status == STATUS_OK)
    else $error("status set on a byte that does not end the frame");

  // results with no payload byte only come from a header and always end the frame
  a_none_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_role == ROLE_NONE |->
      frame_last && byte_offset == 32'd0 && byte_value == 8'd0)
    else $error("role none on a payload item");

  a_too_large_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == STATUS_TOO_LARGE |-> frame_last && byte_role == ROLE_NONE)
    else $error("too-large status on a payload byte");

  // the last payload byte sits at offset length minus one
  a_last_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last && byte_role != ROLE_NONE |->
      ({1'b0, byte_offset} + 33'd1) == {1'b0, frame_length})
    else $error("frame ended at the wrong offset");

endmodule

bind length_prefixed_frame_field_parser lpffp_checker u_lpffp_checker (.*);

// ===== dv/frame_tag_checker.sv =====
// checker for the frame field parser: predicts the tagged bytes and compares them
`timescale 1ns / 100ps

module frame_tag_checker
  import lpffp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  frame_opcode,
  input  logic [31:0] frame_length,
  input  logic [7:0]  byte_value,
  input  logic [2:0]  byte_role,
  input  logic [31:0] byte_offset,
  input  logic        frame_last,
  input  logic [2:0]  frame_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          awaiting,
  output int          tags_seen
);

  cfg_t        regs;
  phase_t      parse_at;
  logic [1:0]  ext_seen;
  logic [2:0]  cur_op;
  logic [31:0] decl_len;
  logic [31:0] taken;
  logic [15:0] name_len;
  result_t     awaited_tags [$];

  function automatic kind_t code_kind(input logic [2:0] op);
    if (op == regs.open_code) return KIND_OPEN;
    if (op == regs.close_code) return KIND_CLOSE;
    if (op == regs.stream_code) return KIND_STREAM;
    if (op == regs.confirm_code) return KIND_CONFIRM;
    return KIND_UNKNOWN;
  endfunction

  function automatic logic [2:0] closing_status();
    kind_t       k;
    logic [32:0] fixed_len;
    logic [32:0] need;
    k = code_kind(cur_op);
    fixed_len = {30'd0, (k == KIND_CLOSE) ? FIXED_OTHER : FIXED_OPEN};
    need = fixed_len + {17'd0, name_len};
    if (k == KIND_UNKNOWN) return STATUS_UNKNOWN;
    if ({1'b0, decl_len} < fixed_len) return STATUS_SHORT;
    if (need > {1'b0, decl_len}) return STATUS_OVERRUN;
    return STATUS_OK;
  endfunction

  function automatic logic [2:0] role_at(input kind_t k, input logic [31:0] off);
    logic [32:0] name_from;
    logic [32:0] name_to;
    logic [32:0] at;
    name_from = {30'd0, (k == KIND_OPEN) ? FIXED_OPEN : FIXED_OTHER};
    name_to = name_from + {17'd0, name_len};
    at = {1'b0, off};
    if (k == KIND_UNKNOWN) return ROLE_OTHER;
    if (k == KIND_OPEN && at < {30'd0, BAUD_BYTES}) return ROLE_BAUD;
    if (at < name_from) return ROLE_NAME_LEN;
    if (at < name_to) return ROLE_NAME_CHAR;
    if ((k == KIND_STREAM || k == KIND_CONFIRM) && at < name_to + {30'd0, XFER_ID_BYTES})
      return ROLE_XFER_ID;
    if (k == KIND_STREAM) return ROLE_DATA;
    return ROLE_OTHER;
  endfunction

  task automatic push_tag(input logic [7:0] value, input logic [2:0] role,
                          input logic [31:0] off, input logic last,
                          input logic [2:0] status);
    result_t t;
    t.valid  = 1'b1;
    t.opcode = cur_op;
    t.length = decl_len;
    t.value  = value;
    t.role   = role;
    t.offset = off;
    t.last   = last;
    t.status = status;
    awaited_tags.push_back(t);
  endtask

  task automatic length_settled();
    if (decl_len > regs.max_frame_length) begin
      // parser stays dead until reset
      parse_at = PH_HALTED;
      push_tag(8'd0, ROLE_NONE, 32'd0, 1'b1, STATUS_TOO_LARGE);
    end else begin
      taken = 32'd0;
      name_len = 16'd0;
      if (decl_len == 32'd0) begin
        push_tag(8'd0, ROLE_NONE, 32'd0, 1'b1, closing_status());
        parse_at = PH_HEADER;
      end else begin
        parse_at = PH_PAYLOAD;
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    kind_t       k;
    logic [2:0]  role;
    logic [31:0] off;
    logic        last;
    case (parse_at)
      PH_HALTED: ;
      PH_HEADER: begin
        cur_op = b[2:0];
        if (b[7:3] == LEN_EXTENDED) begin
          decl_len = 32'd0;
          ext_seen = 2'd0;
          parse_at = PH_EXT;
        end else begin
          decl_len = {27'd0, b[7:3]};
          length_settled();
        end
      end
      PH_EXT: begin
        decl_len = {decl_len[23:0], b};
        if (ext_seen == EXT_LAST_BYTE) length_settled();
        else ext_seen = ext_seen + 2'd1;
      end
      PH_PAYLOAD: begin
        k = code_kind(cur_op);
        off = taken;
        role = role_at(k, off);
        if (role == ROLE_NAME_LEN) name_len = {name_len[7:0], b};
        taken = off + 32'd1;
        last = (taken >= decl_len);
        push_tag(b, role, off, last, last ? closing_status() : STATUS_OK);
        if (last) parse_at = PH_HEADER;
      end
      default: parse_at = PH_HEADER;
    endcase
  endtask

  task automatic match_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t t;
    if (rst) begin
      regs.open_code        = RST_OPEN_CODE;
      regs.close_code       = RST_CLOSE_CODE;
      regs.stream_code      = RST_STREAM_CODE;
      regs.confirm_code     = RST_CONFIRM_CODE;
      regs.max_frame_length = RST_MAX_LENGTH;
      parse_at = PH_HEADER;
      ext_seen = 2'd0;
      cur_op   = 3'd0;
      decl_len = 32'd0;
      taken    = 32'd0;
      name_len = 16'd0;
      awaited_tags.delete();
    end else begin
      // results first, so an item taken at this edge cannot cover a stray result
      if (out_valid && out_ready) begin
        tags_seen++;
        if (awaited_tags.size() == 0) begin
          $error("result with nothing expected: opcode 0x%0h offset 0x%0h role %0d",
                 frame_opcode, byte_offset, byte_role);
          mismatches++;
        end else begin
          t = awaited_tags.pop_front();
          match_field("frame_opcode", 32'(t.opcode), 32'(frame_opcode));
          match_field("frame_length", t.length, frame_length);
          match_field("byte_value", 32'(t.value), 32'(byte_value));
          match_field("byte_role", 32'(t.role), 32'(byte_role));
          match_field("byte_offset", t.offset, byte_offset);
          match_field("frame_last", 32'(t.last), 32'(frame_last));
          match_field("frame_status", 32'(t.status), 32'(frame_status));
        end
      end
      if (in_valid && in_ready) take_byte(data_byte);
      // a write lands after any item taken at the same edge
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OPEN_CODE:    regs.open_code = cfg_data[2:0];
          CFG_CLOSE_CODE:   regs.close_code = cfg_data[2:0];
          CFG_STREAM_CODE:  regs.stream_code = cfg_data[2:0];
          CFG_CONFIRM_CODE: regs.confirm_code = cfg_data[2:0];
          CFG_MAX_LENGTH:   regs.max_frame_length = cfg_data;
          default: ;
        endcase
      end
    end
    awaiting <= awaited_tags.size();
  end

endmodule

// ===== dv/tb_length_prefixed_frame_field_parser.sv =====
// testbench top for the frame field parser: clock, reset, frame stimulus and verdict
`timescale 1ns / 100ps

module tb_length_prefixed_frame_field_parser;
  import lpffp_pkg::*;

  localparam int LIMIT_CYCLES = 400_000;
  localparam int HOLD_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  frame_opcode;
  logic [31:0] frame_length;
  logic [7:0]  byte_value;
  logic [2:0]  byte_role;
  logic [31:0] byte_offset;
  logic        frame_last;
  logic [2:0]  frame_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'd0;
  int          mismatches;
  int          awaiting;
  int          tags_seen;

  logic [2:0]  codes [4];
  logic [31:0] cur_max;
  int          items_sent = 0;
  int          reg_writes = 0;
  int          burst_left = 0;
  int          cycles = 0;
  bit          hold_req = 1'b0;

  length_prefixed_frame_field_parser u_dut (.*);
  frame_tag_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles, awaiting);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall modes, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int span;
    int tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (tick % 3 != 0);
          endcase
        end
      end
    end
  end

  task automatic offer_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    // header bytes give no result and may still be in flight
    repeat (6) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_config(input logic [2:0] o, input logic [2:0] c,
                            input logic [2:0] s, input logic [2:0] f,
                            input logic [31:0] m);
    write_reg(CFG_OPEN_CODE, 32'(o));
    write_reg(CFG_CLOSE_CODE, 32'(c));
    write_reg(CFG_STREAM_CODE, 32'(s));
    write_reg(CFG_CONFIRM_CODE, 32'(f));
    write_reg(CFG_MAX_LENGTH, m);
    codes[0] = o;
    codes[1] = c;
    codes[2] = s;
    codes[3] = f;
    cur_max = m;
  endtask

  task automatic offer_length_header(input logic [2:0] op, input logic [31:0] len32,
                                     input bit ext);
    if (ext) begin
      offer_byte({LEN_EXTENDED, op});
      for (int i = 0; i < 4; i++) offer_byte(len32[31 - 8 * i -: 8]);
    end else begin
      offer_byte({len32[4:0], op});
    end
  endtask

  // one frame: mostly well-formed layouts, some short, overrun or random content
  task automatic offer_frame();
    int          flavor;
    int          kind;
    int          fixed_len;
    int          nl_at;
    int          len;
    int          mode;
    logic [2:0]  op;
    logic [15:0] nlen;
    bit          junk;
    flavor = $urandom_range(0, 4);
    if (flavor < 4) begin
      op = codes[flavor];
    end else begin
      do op = 3'($urandom_range(0, 7));
      while (op == codes[0] || op == codes[1] || op == codes[2] || op == codes[3]);
    end
    kind = 4;
    for (int i = 3; i >= 0; i--) if (op == codes[i]) kind = i;
    fixed_len = (kind == 1) ? 2 : 6;
    nl_at = (kind == 0) ? 4 : 0;
    nlen = 16'($urandom_range(0, 6));
    junk = 1'b0;
    mode = $urandom_range(0, 49);
    if (mode < 3) begin
      len = $urandom_range(0, fixed_len - 1);
    end else if (mode < 6) begin
      nlen = 16'($urandom());
      len = fixed_len + $urandom_range(0, 20);
    end else if (mode < 9) begin
      junk = 1'b1;
      len = $urandom_range(0, 30);
    end else if (mode == 9) begin
      nlen = 16'($urandom_range(0, 200));
      len = fixed_len + nlen + $urandom_range(0, 100);
    end else begin
      len = fixed_len + nlen + $urandom_range(0, 6);
    end
    if (len > cur_max) len = int'(cur_max);
    offer_length_header(op, 32'(len), (len >= 31) || ($urandom_range(0, 5) == 0));
    for (int off = 0; off < len; off++) begin
      if (!junk && kind < 4 && off == nl_at) offer_byte(nlen[15:8]);
      else if (!junk && kind < 4 && off == nl_at + 1) offer_byte(nlen[7:0]);
      else offer_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_frames(input int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) offer_frame();
  endtask

  initial begin : stimulus
    logic [7:0]  opening [26];
    logic [2:0]  op;
    logic [31:0] oversize;
    opening = '{
      8'h00,                                           // empty open frame, short
      8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,               // extended empty, unknown opcode
      8'h11, 8'h00, 8'h01,                             // close, name overruns
      8'h3A, 8'h00, 8'h00, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h5A, // stream with one data
      8'h30, 8'h00, 8'h01, 8'hC2, 8'h00, 8'h00, 8'h00, // open, baud and empty name
      8'h0B, 8'hA5                                     // confirm, short
    };
    codes[0] = RST_OPEN_CODE;
    codes[1] = RST_CLOSE_CODE;
    codes[2] = RST_STREAM_CODE;
    codes[3] = RST_CONFIRM_CODE;
    cur_max = RST_MAX_LENGTH;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening[i]) offer_byte(opening[i]);
    wait_drained();

    run_frames(250);
    wait_drained();

    // remapped codes at the value extremes, no length limit to speak of
    set_config(3'd7, 3'd0, 3'd5, 3'd4, 32'hFFFF_FFFF);
    run_frames(150);
    hold_req = 1'b1;
    run_frames(150);
    wait_drained();

    // duplicate codes resolve in open, close, stream, confirm order; tight limit
    set_config(3'd5, 3'd5, 3'd6, 3'd6, 32'd20);
    run_frames(150);
    wait_drained();
    set_config(3'd2, 3'd2, 3'd2, 3'd2, 32'd20);
    run_frames(100);
    wait_drained();

    // zero limit: only empty frames get through
    set_config(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
               3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 32'd0);
    run_frames(100);
    wait_drained();

    repeat (4) begin
      set_config(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                 32'($urandom_range(21, 500)));
      run_frames(100);
      wait_drained();
    end

    // oversize length halts the parser; later items are taken and dropped
    set_config(RST_OPEN_CODE, RST_CLOSE_CODE, RST_STREAM_CODE, RST_CONFIRM_CODE,
               32'($urandom_range(0, 29)));
    op = 3'($urandom_range(0, 7));
    oversize = cur_max + 32'd1;
    offer_length_header(op, oversize, $urandom_range(0, 1) == 1);
    repeat (20) offer_byte(8'($urandom_range(0, 255)));
    wait_drained();

    $display("sent %0d bytes, checked %0d tagged results, %0d register writes",
             items_sent, tags_seen, reg_writes);
    $display("covered default, remapped and duplicate opcodes, limits 0 to max, halt");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== length_prefixed_frame_field_parser.f =====
rtl/lpffp_pkg.sv
rtl/lpffp_engine.sv
rtl/length_prefixed_frame_field_parser.sv
rtl/lpffp_checker.sv
dv/frame_tag_checker.sv
dv/tb_length_prefixed_frame_field_parser.sv
